// ===== sv/tprl_pkg.sv =====
// Package for timestamp pose range lookup: command codes and field widths.
// No dependencies.
`default_nettype none
package tprl_pkg;
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam int TIME_W  = 48;
    localparam int COORD_W = 24;
    localparam int RANGE_W = 25;
    localparam int IDX_W   = 10;
    localparam int SQ_W    = 52;

    typedef struct packed {
        logic [TIME_W-1:0]  t;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_entry;
endpackage
`default_nettype wire

// ===== sv/timestamp_pose_range_lookup_top.sv =====
// Timestamp pose range lookup: table of scanner poses with time search.
// Load and clear complete at the accepting edge and keep busy low. A query runs
// a binary search (issue read, wait for data, compare per step), then fetches
// and tests the entry, forms the squares and their sum, and takes the square
// root; the next word is accepted in the strobe cycle. Sync active-low reset
// empties the table; memory is not cleared.
`default_nettype none
module timestamp_pose_range_lookup_top
    import tprl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_cmd,
    input  wire logic [TIME_W-1:0]         i_time_stamp,
    input  wire logic signed [COORD_W-1:0] i_pos_x,
    input  wire logic signed [COORD_W-1:0] i_pos_y,
    input  wire logic signed [COORD_W-1:0] i_pos_z,
    output logic                           o_strobe,
    output logic                           o_range_valid,
    output logic [RANGE_W-1:0]             o_range_mm,
    output logic [IDX_W-1:0]               o_pose_index
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_STEP, S_CMP, S_FETCH, S_SQ, S_SUM, S_ROOT
    } t_state;

    // pose memory, one word per entry
    t_entry mem [TABLE_DEPTH];
    t_entry r_rd;
    logic   [AW-1:0] r_addr;

    t_state r_state;
    logic [CW-1:0] r_count, r_first, r_cnt, r_it;
    logic [TIME_W-1:0] r_qt;
    logic signed [COORD_W-1:0] r_qx, r_qy, r_qz;
    logic [2*COORD_W+1:0] r_sx, r_sy, r_sz;
    logic signed [COORD_W:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0] r_sum;
    logic r_sq_start;
    logic r_xyok;

    // differences sign-extended to the full square width
    logic signed [2*COORD_W+1:0] dx_ext, dy_ext, dz_ext;

    logic sq_done;
    logic [RANGE_W:0] sq_root;

    logic wr_en;
    logic [CW-1:0] step;

    assign wr_en = start && !busy && t_cmd'(i_cmd) == CMD_LOAD
                   && r_count < CW'(TABLE_DEPTH);
    assign step  = r_cnt >> 1;
    assign busy  = (r_state != S_IDLE);

    assign dx_ext = (2*COORD_W+2)'(r_dx);
    assign dy_ext = (2*COORD_W+2)'(r_dy);
    assign dz_ext = (2*COORD_W+2)'(r_dz);

    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem[r_count[AW-1:0]] <= '{t: i_time_stamp, x: i_pos_x,
                                      y: i_pos_y, z: i_pos_z};
        r_rd <= mem[r_addr];
    end

    tprl_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_sq_start),
        .i_value(r_sum),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    always_ff @(posedge i_clk) begin
        o_strobe   <= 1'b0;
        r_sq_start <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (t_cmd'(i_cmd))
                            CMD_LOAD:  if (wr_en) r_count <= r_count + 1'b1;
                            CMD_CLEAR: r_count <= '0;
                            CMD_QUERY: begin
                                r_qt    <= i_time_stamp;
                                r_qx    <= i_pos_x;
                                r_qy    <= i_pos_y;
                                r_qz    <= i_pos_z;
                                r_first <= '0;
                                r_cnt   <= r_count;
                                r_state <= S_STEP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_STEP: begin
                    // issue read of the midpoint, or finish the search
                    if (r_cnt == '0) begin
                        if (r_first == '0) begin
                            o_strobe      <= 1'b1;
                            o_range_valid <= 1'b0;
                            o_range_mm    <= '0;
                            o_pose_index  <= '0;
                            r_state       <= S_IDLE;
                        end else begin
                            r_addr  <= AW'(r_first - 1'b1);
                            r_it    <= r_first - 1'b1;
                            r_state <= S_FETCH;
                        end
                    end else begin
                        r_it    <= r_first + step;
                        r_addr  <= AW'(r_first + step);
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    // memory read data is registered from the address; wait here for it
                    r_state <= S_SQ;
                    r_xyok  <= 1'b0;
                end
                S_FETCH: begin
                    r_state <= S_SQ;
                    r_xyok  <= 1'b1;
                end
                S_SQ: begin
                    if (!r_xyok) begin
                        if (r_rd.t < r_qt) begin
                            r_first <= r_it + 1'b1;
                            r_cnt   <= r_cnt - step - 1'b1;
                        end else begin
                            r_cnt <= step;
                        end
                        r_state <= S_STEP;
                    end else if (r_rd.x == '0 || r_rd.y == '0) begin
                        o_strobe      <= 1'b1;
                        o_range_valid <= 1'b0;
                        o_range_mm    <= '0;
                        o_pose_index  <= IDX_W'(r_it);
                        r_state       <= S_IDLE;
                    end else begin
                        r_dx    <= $signed({r_rd.x[COORD_W-1], r_rd.x})
                                   - $signed({r_qx[COORD_W-1], r_qx});
                        r_dy    <= $signed({r_rd.y[COORD_W-1], r_rd.y})
                                   - $signed({r_qy[COORD_W-1], r_qy});
                        r_dz    <= $signed({r_rd.z[COORD_W-1], r_rd.z})
                                   - $signed({r_qz[COORD_W-1], r_qz});
                        r_state <= S_SUM;
                        r_xyok  <= 1'b0;
                    end
                end
                S_SUM: begin
                    if (!r_xyok) begin
                        r_sx   <= dx_ext * dx_ext;
                        r_sy   <= dy_ext * dy_ext;
                        r_sz   <= dz_ext * dz_ext;
                        r_xyok <= 1'b1;
                    end else begin
                        r_sum      <= SQ_W'(r_sx) + SQ_W'(r_sy) + SQ_W'(r_sz);
                        r_sq_start <= 1'b1;
                        r_state    <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (sq_done) begin
                        o_strobe      <= 1'b1;
                        o_range_valid <= 1'b1;
                        o_range_mm    <= RANGE_W'(sq_root);
                        o_pose_index  <= IDX_W'(r_it);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/tprl_isqrt.sv =====
// Iterative floor square root, restoring method, one result bit per cycle.
// Depends on tprl_pkg.
`default_nettype none
module tprl_isqrt
    import tprl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [SQ_W-1:0]    i_value,
    output logic                    o_done,
    output logic [RANGE_W+1-1:0]    o_root
);
    localparam int ROOT_W = SQ_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    // r_res carries the partial root scaled by the current bit weight
    logic [SQ_W-1:0]   r_rem, r_bit, n_rem, n_bit;
    logic [SQ_W-1:0]   r_res, n_res;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [SQ_W-1:0]   trial;

    assign trial = r_res + r_bit;

    always_comb begin
        if (r_rem >= trial) begin
            n_rem = r_rem - trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_rem = r_rem;
            n_res = r_res >> 1;
        end
        n_bit = r_bit >> 2;
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_rem  <= i_value;
            r_res  <= '0;
            r_bit  <= SQ_W'(1) << (SQ_W - 2);
            r_cnt  <= CNT_W'(ROOT_W);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_bit <= n_bit;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    assign o_root = (RANGE_W+1)'(r_res);
endmodule
`default_nettype wire

// ===== sv/tprl_checker.sv =====
// Port-level checks for the timestamp pose range lookup top level.
// Depends on tprl_pkg; bound to timestamp_pose_range_lookup_top.
`default_nettype none
module tprl_checker
    import tprl_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [1:0]         i_cmd,
    input wire logic               o_strobe,
    input wire logic               o_range_valid,
    input wire logic [RANGE_W-1:0] o_range_mm
);
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("double strobe");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_range_valid |-> o_range_mm == '0) else $error("range");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd == CMD_QUERY |=> busy) else $error("busy");
    a_strobe_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)) else $error("stray strobe");
endmodule

bind timestamp_pose_range_lookup_top tprl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_cmd(i_cmd), .o_strobe(o_strobe), .o_range_valid(o_range_valid),
    .o_range_mm(o_range_mm)
);
`default_nettype wire

// ===== sim/timestamp_pose_range_lookup_top_tb.sv =====
// Testbench for timestamp_pose_range_lookup_top: pose table loads, time searches, ranges.
// Depends on tprl_pkg and the block's RTL; self-checking against an in-bench predictor.
`timescale 1ns / 1ps
module timestamp_pose_range_lookup_top_tb;
    import tprl_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int CYCLE_CAP  = 1000000;

    typedef struct {
        logic              valid;
        logic [RANGE_W-1:0] range;
        logic [IDX_W-1:0]   index;
    } t_range_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                i_cmd = CMD_NONE;
    logic [TIME_W-1:0]         i_time_stamp = '0;
    logic signed [COORD_W-1:0] i_pos_x = '0;
    logic signed [COORD_W-1:0] i_pos_y = '0;
    logic signed [COORD_W-1:0] i_pos_z = '0;
    logic                      o_strobe;
    logic                      o_range_valid;
    logic [RANGE_W-1:0]        o_range_mm;
    logic [IDX_W-1:0]          o_pose_index;

    timestamp_pose_range_lookup_top #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_time_stamp(i_time_stamp),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .o_strobe(o_strobe), .o_range_valid(o_range_valid),
        .o_range_mm(o_range_mm), .o_pose_index(o_pose_index)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the pose table
    logic [TIME_W-1:0]         pose_time [DEPTH];
    logic signed [COORD_W-1:0] pose_x [DEPTH];
    logic signed [COORD_W-1:0] pose_y [DEPTH];
    logic signed [COORD_W-1:0] pose_z [DEPTH];
    int                        pose_count = 0;

    t_range_word pending_ranges[$];
    int          error_count = 0;
    int          sender_idle_pct = 0;
    int          word_count = 0;

    // Lower bound: first index whose time is not below t
    function automatic int first_not_before(logic [TIME_W-1:0] t);
        int first;
        int count;
        int step;
        first = 0;
        count = pose_count;
        while (count > 0) begin
            step = count / 2;
            if (first + step < DEPTH && pose_time[first + step] < t) begin
                first = first + step + 1;
                count = count - step - 1;
            end else begin
                count = step;
            end
        end
        return first;
    endfunction

    function automatic logic [63:0] diff_sq(logic signed [COORD_W-1:0] a,
                                            logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return 64'(d * d);
    endfunction

    // Sum of three squares stays under 2^50, so a 26-bit root suffices
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] trial;
        res = '0;
        for (int b = 25; b >= 0; b--) begin
            trial = res | (64'd1 << b);
            if (trial * trial <= v) res = trial;
        end
        return res;
    endfunction

    function automatic t_range_word range_for(logic [TIME_W-1:0] t,
                                              logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y,
                                              logic signed [COORD_W-1:0] z);
        t_range_word w;
        int lb;
        int k;
        w.valid = 1'b0;
        w.range = '0;
        w.index = '0;
        lb = first_not_before(t);
        if (lb > 0 && lb <= pose_count) begin
            k = lb - 1;
            w.index = IDX_W'(k);
            if (pose_x[k] != 0 && pose_y[k] != 0) begin
                w.valid = 1'b1;
                w.range = RANGE_W'(floor_root(diff_sq(pose_x[k], x)
                                  + diff_sq(pose_y[k], y) + diff_sq(pose_z[k], z)));
            end
        end
        return w;
    endfunction

    // Sends one word, holding start until busy is low at an edge
    task automatic send_word(t_cmd c, logic [TIME_W-1:0] t,
                             logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(6, 1);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= c;
        i_time_stamp <= t;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_pos_z      <= z;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        word_count++;
        case (c)
            CMD_LOAD: begin
                if (pose_count < DEPTH) begin
                    pose_time[pose_count] = t;
                    pose_x[pose_count] = x;
                    pose_y[pose_count] = y;
                    pose_z[pose_count] = z;
                    pose_count++;
                end
            end
            CMD_CLEAR: pose_count = 0;
            CMD_QUERY: pending_ranges.insert(pending_ranges.size(),
                                             range_for(t, x, y, z));
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0: return 24'h000000;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    // Result checker: every strobe pops the oldest expected word
    always @(posedge i_clk) begin
        t_range_word w;
        if (i_rst_n && o_strobe) begin
            if (pending_ranges.size() == 0) begin
                $display("%0t: unexpected result valid=%0d range=%0d index=%0d",
                         $time, o_range_valid, o_range_mm, o_pose_index);
                error_count++;
            end else begin
                w = pending_ranges.pop_front();
                if (o_range_valid !== w.valid) begin
                    $display("%0t: range_valid expected %0d actual %0d",
                             $time, w.valid, o_range_valid);
                    error_count++;
                end
                if (o_range_mm !== w.range) begin
                    $display("%0t: range_mm expected %0d actual %0d",
                             $time, w.range, o_range_mm);
                    error_count++;
                end
                if (o_pose_index !== w.index) begin
                    $display("%0t: pose_index expected %0d actual %0d",
                             $time, w.index, o_pose_index);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Queries on an empty table, then the extreme times and coordinates
    task automatic test_directed();
        send_word(CMD_QUERY, '1, 24'h7FFFFF, 24'h800000, 24'h0);
        send_word(CMD_QUERY, '0, 24'h0, 24'h0, 24'h0);
        send_word(CMD_LOAD, 48'd10, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_word(CMD_LOAD, 48'd20, 24'h000000, 24'h000005, 24'h000001);  // zero x
        send_word(CMD_LOAD, 48'd30, 24'h000007, 24'h000000, 24'h000001);  // zero y
        send_word(CMD_LOAD, 48'd40, 24'h800000, 24'h800000, 24'h800000);
        send_word(CMD_LOAD, 48'hFFFF_FFFF_FFFE, 24'h000003, 24'hFFFFFC, 24'h0);
        send_word(CMD_QUERY, 48'd10, 24'h0, 24'h0, 24'h0);   // none strictly earlier
        send_word(CMD_QUERY, 48'd11, 24'h800000, 24'h800000, 24'h800000);  // max range
        send_word(CMD_QUERY, 48'd21, 24'h1, 24'h1, 24'h1);
        send_word(CMD_QUERY, 48'd31, 24'h1, 24'h1, 24'h1);
        send_word(CMD_QUERY, 48'd41, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_word(CMD_QUERY, '1, 24'h0, 24'h0, 24'h0);
        send_word(CMD_NONE, 48'd50, 24'h1, 24'h1, 24'h1);    // ignored
        send_word(CMD_QUERY, 48'd0, 24'h0, 24'h0, 24'h0);
        send_word(CMD_CLEAR, '0, '0, '0, '0);
        send_word(CMD_QUERY, '1, 24'h1, 24'h1, 24'h1);
        drain();
    endtask

    // Fill past capacity; the extra loads are dropped
    task automatic test_full_table();
        logic [TIME_W-1:0] t;
        send_word(CMD_CLEAR, '0, '0, '0, '0);
        t = 48'd100;
        for (int i = 0; i < DEPTH + 3; i++) begin
            send_word(CMD_LOAD, t, rand_coord(), rand_coord(), rand_coord());
            t = t + $urandom_range(3, 1);
        end
        send_word(CMD_QUERY, '1, rand_coord(), rand_coord(), rand_coord());
        for (int i = 0; i < 12; i++)
            send_word(CMD_QUERY, 48'd99 + $urandom_range(3200),
                      rand_coord(), rand_coord(), rand_coord());
        drain();
    endtask

    // Loads out of order run the same search on the stored table
    task automatic test_unsorted();
        send_word(CMD_CLEAR, '0, '0, '0, '0);
        for (int i = 0; i < 9; i++)
            send_word(CMD_LOAD, 48'($urandom_range(200)), rand_coord(), rand_coord(),
                      rand_coord());
        for (int i = 0; i < 10; i++)
            send_word(CMD_QUERY, 48'($urandom_range(210)), rand_coord(), rand_coord(),
                      rand_coord());
        drain();
    endtask

    // Random sequences: clear, sorted loads, queries near the entry times; some noise
    task automatic test_random(int idle_pct, int words);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] base;
        int n;
        int stop_at;
        sender_idle_pct = idle_pct;
        stop_at = word_count + words;
        while (word_count < stop_at) begin
            if ($urandom_range(9) < 8) begin
                send_word(CMD_CLEAR, rand_time(), rand_coord(), rand_coord(), rand_coord());
                n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12);
                base = rand_time() >> $urandom_range(2);
                if (base > 48'hFFFF_FFFF_0000) base = 48'hFFFF_FFFF_0000;
                t = base;
                for (int i = 0; i < n; i++) begin
                    send_word(CMD_LOAD, t, rand_coord(), rand_coord(), rand_coord());
                    t = t + $urandom_range(40);
                end
                repeat ($urandom_range(8, 2))
                    send_word(CMD_QUERY, base - 2 + $urandom_range(40 * n + 4),
                              rand_coord(), rand_coord(), rand_coord());
            end else begin
                repeat ($urandom_range(5, 1))
                    send_word(t_cmd'($urandom_range(3)), rand_time(), rand_coord(),
                              rand_coord(), rand_coord());
            end
        end
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 34;
        test_directed();
        test_unsorted();
        test_full_table();
        test_random(34, 200);
        test_random(52, 200);
        test_random(0, 200);
        drain();
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
